@@ rtl/sma_pkg.sv @@
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants for the moving-average block.
// ----------------------------------------------------------------------------
package sma_pkg;

	// configuration port
	localparam int APB_DATA_W       = 32;
	localparam int APB_ADDR_W       = 3;
	localparam int REG_IDX_W        = 1;
	localparam int WIDTH_REG_BITS   = 9;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_WIDTH = 1'b0;
	localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 9'd1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_OUT
	} sma_state_t;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} sma_div_stat_t;

endpackage

@@ rtl/sma_sample_if.sv @@
// ----------------------------------------------------------------------------
// sma_sample_if
// Valid/ready channel carrying one input sample per beat.
// ----------------------------------------------------------------------------
interface sma_sample_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/sma_mean_if.sv @@
// ----------------------------------------------------------------------------
// sma_mean_if
// Valid/ready channel carrying one window mean per beat.
// ----------------------------------------------------------------------------
interface sma_mean_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] mean;

	modport source (output valid, output mean, input ready);
	modport sink   (input valid, input mean, output ready);
endinterface

@@ rtl/sma_ram.sv @@
// ----------------------------------------------------------------------------
// sma_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module sma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ rtl/sma_div.sv @@
// ----------------------------------------------------------------------------
// sma_div
// Signed-by-unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module sma_div #(
	parameter int DVD_W = 40,
	parameter int DVS_W = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0]        divisor,
	output sma_pkg::sma_div_stat_t  stat,
	output logic signed [DVD_W-1:0] quotient
);
	import sma_pkg::*;

	localparam int CNT_B = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_B-1:0] cnt_q;
	logic             neg_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W:0]   rem_sh;
	logic             fits;
	logic [DVS_W:0]   rem_sub;

	// shift next dividend bit into the partial remainder, trial subtract
	assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_B'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_B'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DVD_W-1];
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

@@ rtl/simple_moving_average_top.sv @@
// ----------------------------------------------------------------------------
// simple_moving_average_top
// Boxcar moving average of a signed Q16.16 sample stream.
// ----------------------------------------------------------------------------
// Usage
//   sample_ch : valid/ready sink, one signed sample per beat.
//   mean_ch   : valid/ready source, one mean per beat once a full window of
//               samples has been seen since the last width write.
//   APB port  : register 0 (byte address 0) is window_width, 9 bits, reset 1.
//               Width 0 acts as 1, widths above WINDOW_MAX act as WINDOW_MAX.
//               A write clears the fill count and the running sum.
// Sequence
//   A sample is taken in IDLE, which also issues the ring RAM read of the
//   leaving sample; READ then updates the running sum. A sample that gives
//   no result goes back to IDLE from READ. One that gives a result starts
//   the serial divider (one quotient bit at a time, SUM_W = 40 bits at the
//   defaults), waits in DIV and is loaded into the output register in OUT.
//   No new sample is taken until the sequencer is back in IDLE.
// Reset / stall
//   arst_n clears the pointer, fill count, sum and width (to 1); the ring RAM
//   is not cleared, entries are only used once written. A stalled receiver
//   holds the mean in the output register; the block still takes the next
//   sample and only waits if a newer mean is ready before the old beat left.
// ----------------------------------------------------------------------------
module simple_moving_average_top #(
	parameter int WINDOW_MAX  = 256,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	sma_sample_if.sink                          sample_ch,
	sma_mean_if.source                          mean_ch,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sma_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [sma_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [sma_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);
	import sma_pkg::*;

	// ring index, window count and sum widths
	localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W = (CNT_W > WIDTH_REG_BITS) ? CNT_W : WIDTH_REG_BITS;
	localparam int IDX_W = ((CNT_W > PTR_W) ? CNT_W : PTR_W) + 1;
	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

	// ---------------------------------------------------------------- config
	logic [WIDTH_REG_BITS-1:0] width_q;
	logic                      cfg_wr;
	logic                      cfg_hit;
	logic [CMP_W-1:0]          width_x;
	logic [CNT_W-1:0]          eff_w;

	assign pready  = 1'b1;
	assign cfg_hit = paddr[APB_ADDR_W-1:2] == REG_WINDOW_WIDTH;
	assign cfg_wr  = psel && penable && pwrite && cfg_hit;
	assign prdata  = cfg_hit ? APB_DATA_W'(width_q) : '0;

	// clamp the programmed width into 1..WINDOW_MAX
	assign width_x = CMP_W'(width_q);
	always_comb begin
		if (width_x == '0) begin
			eff_w = CNT_W'(1);
		end else if (width_x > CMP_W'(WINDOW_MAX)) begin
			eff_w = CNT_W'(WINDOW_MAX);
		end else begin
			eff_w = CNT_W'(width_x);
		end
	end

	// ---------------------------------------------------------------- state
	sma_state_t                  state_q, state_d;
	logic [PTR_W-1:0]            wp_q;
	logic [CNT_W-1:0]            fill_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                        out_valid_q;
	logic signed [SAMPLE_BITS-1:0] mean_q;

	// sequencer controls
	logic in_ready;
	logic take;
	logic upd;
	logic div_start;
	logic load_out;

	// ring RAM
	logic [PTR_W-1:0]       old_idx;
	logic [IDX_W-1:0]       old_diff;
	logic [SAMPLE_BITS-1:0] ring_rdata;

	// sum update
	logic                    full;
	logic [CNT_W-1:0]        fill_nxt;
	logic signed [SUM_W-1:0] old_val;
	logic signed [SUM_W-1:0] sum_nxt;
	logic                    gives_result;

	// divider
	sma_div_stat_t           div_stat;
	logic signed [SUM_W-1:0] div_quo;

	assign take = sample_ch.valid && in_ready;

	// leaving sample sits eff_w slots behind the write pointer
	assign old_diff = IDX_W'(wp_q) - IDX_W'(eff_w);
	assign old_idx  = old_diff[IDX_W-1] ? PTR_W'(old_diff + IDX_W'(WINDOW_MAX))
	                                    : PTR_W'(old_diff);

	sma_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (upd),
		.waddr (wp_q),
		.wdata (sample_q),
		.re    (take),
		.raddr (old_idx),
		.rdata (ring_rdata)
	);

	// read data is only used once the window is full, so never stale/unwritten
	assign full         = fill_q >= eff_w;
	assign fill_nxt     = full ? fill_q : fill_q + 1'b1;
	assign old_val      = full ? SUM_W'($signed(ring_rdata)) : '0;
	assign sum_nxt      = sum_q + SUM_W'(sample_q) - old_val;
	assign gives_result = fill_nxt >= eff_w;

	sma_div #(
		.DVD_W (SUM_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nxt),
		.divisor  (eff_w),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// ---------------------------------------------------------------- FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		upd       = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (sample_ch.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				upd = 1'b1;
				if (gives_result) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// quotient holds in the divider until the output slot frees
				if (!out_valid_q || mean_ch.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RESET;
			wp_q        <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				width_q <= pwdata[WIDTH_REG_BITS-1:0];
				fill_q  <= '0;
				sum_q   <= '0;
			end else if (upd) begin
				fill_q <= fill_nxt;
				sum_q  <= sum_nxt;
			end
			if (upd) begin
				wp_q <= (wp_q == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (mean_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_q <= sample_ch.sample;
		end
		if (load_out) begin
			mean_q <= div_quo[SAMPLE_BITS-1:0];
		end
	end

	assign sample_ch.ready = in_ready;
	assign mean_ch.valid   = out_valid_q;
	assign mean_ch.mean    = mean_q;

	// ---------------------------------------------------------------- checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= eff_w)
		else $error("fill count above window width");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= PTR_W'(WINDOW_MAX - 1))
		else $error("write pointer out of ring");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || mean_ch.ready))
		else $error("mean loaded over an untaken beat");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |=> state_q == ST_OUT)
		else $error("divider result not taken to output stage");
endmodule

@@ test/tb_simple_moving_average_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simple_moving_average_top
// Self-checking bench for the boxcar moving average. A directed table covers
// the sample extremes, truncation toward zero, width 0, an ignored register
// index and masking of the width write. Random phases then sweep window
// widths from 1 up to the clamped maximum. Every mean beat is compared with
// a typed mean from the table or a local predictor of the window state.
// ----------------------------------------------------------------------------
module tb_simple_moving_average_top;

	import sma_pkg::*;

	localparam int WIN_MAX       = 256;
	localparam int SAMPLE_W      = 32;
	localparam int CLK_HALF      = 4;      // 8 ns period
	localparam int RESET_CYCLES  = 12;
	localparam int QUIET_CYCLES  = 64;     // longer than the divide path
	localparam int HOLD_CYCLES   = 300;    // long receiver stall
	localparam int CYCLE_LIMIT   = 500000;

	// register indexes as seen on the APB side
	localparam int WIDTH_REG = int'(REG_WINDOW_WIDTH);
	localparam int SPARE_REG = 1;          // no register behind it

	typedef enum logic {
		ROW_WRITE,
		ROW_SAMPLE
	} row_kind_t;

	// sample mixes for the random phases
	typedef enum logic [1:0] {
		MIX_ANY,
		MIX_HIGH,
		MIX_LOW,
		MIX_SMALL
	} sample_mix_t;

	typedef struct {
		row_kind_t   kind;
		int          reg_idx;
		logic [31:0] value;        // sample, or data for a write
		bit          typed;        // mean given below rather than predicted
		logic [31:0] typed_mean;
	} stim_row_t;

	// Directed table. Typed means are those obvious by inspection: width 1
	// (and width 0, which acts as 1) echoes the sample; a window of equal
	// extremes gives that extreme back.
	stim_row_t stim_table [24] = '{
		'{ROW_SAMPLE, 0,         32'h0000_0000, 1'b1, 32'h0000_0000},
		'{ROW_SAMPLE, 0,         32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
		'{ROW_SAMPLE, 0,         32'h8000_0000, 1'b1, 32'h8000_0000},
		'{ROW_SAMPLE, 0,         32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{ROW_SAMPLE, 0,         32'h0001_0000, 1'b1, 32'h0001_0000},
		'{ROW_WRITE,  WIDTH_REG, 32'h0000_0000, 1'b0, 32'h0},
		'{ROW_SAMPLE, 0,         32'h1234_5678, 1'b1, 32'h1234_5678},
		'{ROW_SAMPLE, 0,         32'h8000_0000, 1'b1, 32'h8000_0000},
		'{ROW_WRITE,  WIDTH_REG, 32'h0000_0002, 1'b0, 32'h0},
		'{ROW_SAMPLE, 0,         32'h7FFF_FFFF, 1'b0, 32'h0},
		'{ROW_SAMPLE, 0,         32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
		'{ROW_SAMPLE, 0,         32'h8000_0000, 1'b0, 32'h0},   // -1/2 -> 0
		'{ROW_SAMPLE, 0,         32'h8000_0000, 1'b1, 32'h8000_0000},
		'{ROW_SAMPLE, 0,         32'h0000_0003, 1'b0, 32'h0},   // odd negative sum
		'{ROW_WRITE,  SPARE_REG, 32'h0000_0005, 1'b0, 32'h0},   // must be ignored
		'{ROW_SAMPLE, 0,         32'hFFFF_FFFD, 1'b0, 32'h0},
		'{ROW_SAMPLE, 0,         32'hFFFF_FFFF, 1'b0, 32'h0},
		'{ROW_WRITE,  WIDTH_REG, 32'hFFFF_FE03, 1'b0, 32'h0},   // upper bits dropped
		'{ROW_SAMPLE, 0,         32'h0000_0001, 1'b0, 32'h0},
		'{ROW_SAMPLE, 0,         32'h0000_0002, 1'b0, 32'h0},
		'{ROW_SAMPLE, 0,         32'h0000_0004, 1'b0, 32'h0},
		'{ROW_SAMPLE, 0,         32'hFFFF_FFF8, 1'b0, 32'h0},   // -2/3 -> 0
		'{ROW_SAMPLE, 0,         32'h5555_5555, 1'b0, 32'h0},
		'{ROW_SAMPLE, 0,         32'hAAAA_AAAA, 1'b0, 32'h0}
	};

	logic clk;
	logic arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	sma_sample_if #(.W(SAMPLE_W)) sample_bus ();
	sma_mean_if   #(.W(SAMPLE_W)) mean_bus ();

	simple_moving_average_top #(
		.WINDOW_MAX (WIN_MAX),
		.SAMPLE_BITS(SAMPLE_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_ch(sample_bus),
		.mean_ch  (mean_bus),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// ------------------------------------------------------------------------
	// Predictor state: the bench's own copy of the window.
	// ------------------------------------------------------------------------
	logic [WIDTH_REG_BITS-1:0] width_reg = WIDTH_RESET;
	logic signed [31:0]        ring [WIN_MAX];
	logic [7:0]                wr_ptr   = '0;
	logic [8:0]                fill_cnt = '0;
	logic signed [39:0]        run_sum  = '0;

	logic signed [31:0] expected_means [$];   // means still owed by the block

	int unsigned err_count   = 0;
	int unsigned items_sent  = 0;
	int unsigned cycle_count = 0;
	bit          no_idle     = 1'b0;          // last part of the run
	bit          hold_req    = 1'b0;          // asks the receiver for a long stall

	// ------------------------------------------------------------------------
	// Clock, cycle counter, watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// width 0 behaves as 1, anything past the ring size as the ring size
	function automatic int unsigned eff_width(logic [WIDTH_REG_BITS-1:0] w);
		if (w == 0)
			return 1;
		if (w > WIN_MAX)
			return WIN_MAX;
		return 32'(w);
	endfunction

	// one sample into the window; the leaving sample is read before the
	// new one overwrites its slot (matters at full ring size)
	task automatic advance_window(input logic [31:0] s, output bit has_mean,
			output logic signed [31:0] mean_out);
		int unsigned w;
		int unsigned old_idx;
		longint      quot;
		w = eff_width(width_reg);
		if (fill_cnt >= w) begin
			old_idx = (int'(wr_ptr) + WIN_MAX - w) % WIN_MAX;
			run_sum = run_sum - ring[old_idx];
		end else begin
			fill_cnt = fill_cnt + 9'd1;
		end
		ring[wr_ptr] = $signed(s);
		run_sum      = run_sum + $signed(s);
		wr_ptr       = wr_ptr + 8'd1;
		has_mean     = (fill_cnt >= w);
		quot         = longint'(run_sum) / longint'(w);   // truncates toward zero
		mean_out     = quot[31:0];
	endtask

	task automatic apply_write(input int idx, input logic [31:0] data);
		if (idx == WIDTH_REG) begin
			width_reg = data[WIDTH_REG_BITS-1:0];
			fill_cnt  = '0;
			run_sum   = '0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Mismatch reporting and the mean checker
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: mismatch, %s: got %h, want %h", $time, what, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && mean_bus.valid === 1'b1 && mean_bus.ready === 1'b1) begin
			if (expected_means.size() == 0) begin
				report_mismatch("mean beat with nothing owed", mean_bus.mean, 'x);
			end else begin
				logic signed [31:0] want;
				want = expected_means.pop_front();
				if (mean_bus.mean !== want)
					report_mismatch("mean", mean_bus.mean, want);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random ready, bursts of back-pressure, one long hold on
	// request so the block fills up and stalls its sample input.
	// ------------------------------------------------------------------------
	initial begin
		mean_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				mean_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (no_idle || $urandom_range(0, 3) != 0) begin
				mean_bus.ready <= 1'b1;
				repeat ($urandom_range(0, 23)) @(negedge clk);
			end else begin
				mean_bus.ready <= 1'b0;
				repeat ($urandom_range(0, 17)) @(negedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sample side
	// ------------------------------------------------------------------------

	// Offer one beat, hold it until taken, then update the predictor.
	// valid stays up after the beat; the next call or a gap decides at the
	// next falling edge.
	task automatic send_sample(input logic [31:0] s, input bit use_typed,
			input logic [31:0] typed_mean);
		bit                 has_mean;
		logic signed [31:0] pred;
		@(negedge clk);
		sample_bus.valid  <= 1'b1;
		sample_bus.sample <= s;
		do @(posedge clk); while (sample_bus.ready !== 1'b1);
		advance_window(s, has_mean, pred);
		if (use_typed)
			expected_means.push_back(typed_mean);
		else if (has_mean)
			expected_means.push_back(pred);
		items_sent++;
	endtask

	// idle gap on the sample side; junk on the data lines must be ignored
	task automatic sender_gap(input int n);
		@(negedge clk);
		sample_bus.valid  <= 1'b0;
		sample_bus.sample <= $urandom;
		repeat (n - 1) @(negedge clk);
	endtask

	// drop valid, wait for every owed mean, then let the block settle
	task automatic go_quiet();
		@(negedge clk);
		sample_bus.valid <= 1'b0;
		while (expected_means.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] gen_sample(input sample_mix_t mix);
		case (mix)
			MIX_HIGH:  return 32'h7FFF_FFFF - $urandom_range(0, 255);
			MIX_LOW:   return 32'h8000_0000 + $urandom_range(0, 255);
			MIX_SMALL: return 32'($urandom_range(0, 2047)) - 32'd1024;
			default: begin
				if ($urandom_range(0, 7) == 0)
					return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
				return $urandom;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// APB: setup then access; pready is waited for although tied high
	// ------------------------------------------------------------------------
	task automatic apb_write(input int idx, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(idx * 4);
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		apply_write(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// read back the width register and compare with the predictor's copy
	task automatic apb_check_width();
		logic [APB_DATA_W-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APB_ADDR_W'(WIDTH_REG * 4);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== APB_DATA_W'(width_reg))
			report_mismatch("window_width readback", got, APB_DATA_W'(width_reg));
	endtask

	// one random phase: new width, then n beats of the given mix
	task automatic run_phase(input logic [31:0] width_val, input int n_items,
			input sample_mix_t mix, input bit gaps_on, input bit pressure);
		go_quiet();
		apb_write(WIDTH_REG, width_val);
		apb_check_width();
		if (pressure)
			hold_req = 1'b1;
		repeat (n_items) begin
			if (gaps_on && !no_idle && $urandom_range(0, 4) == 0)
				sender_gap($urandom_range(1, 18));
			send_sample(gen_sample(mix), 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned w;

		arst_n            = 1'b0;
		sample_bus.valid  = 1'b0;
		sample_bus.sample = '0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, starting from the reset width of 1
		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_WRITE) begin
				go_quiet();
				apb_write(stim_table[i].reg_idx, stim_table[i].value);
				apb_check_width();
			end else begin
				if ($urandom_range(0, 3) == 0)
					sender_gap($urandom_range(1, 18));
				send_sample(stim_table[i].value, stim_table[i].typed,
					stim_table[i].typed_mean);
			end
		end

		// random phases: the width extremes first, then a spread of small ones
		run_phase(32'd1, 20, MIX_ANY, 1'b1, 1'b0);
		// back-to-back beats against a long receiver hold
		run_phase(32'($urandom_range(2, 12)), 40, MIX_ANY, 1'b0, 1'b1);
		run_phase(32'd511, 256 + 8, MIX_LOW, 1'b1, 1'b0);
		repeat (4) begin
			w = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 32);
			run_phase(32'(w), eff_width(w[8:0]) + $urandom_range(10, 24),
				sample_mix_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0);
		end

		// closing phase at full rate on both sides
		no_idle = 1'b1;
		run_phase(32'($urandom_range(1, 16)), 40, MIX_ANY, 1'b0, 1'b0);

		go_quiet();
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ simple_moving_average_top.f @@
rtl/sma_pkg.sv
rtl/sma_sample_if.sv
rtl/sma_mean_if.sv
rtl/sma_ram.sv
rtl/sma_div.sv
rtl/simple_moving_average_top.sv
test/tb_simple_moving_average_top.sv
